// File: design/tpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pkg
// Types and codes shared by the timestamp priority queue and its cells.
// ----------------------------------------------------------------------------
package tpq_pkg;

	typedef enum logic [1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_UPDATE = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  in_seqnum;
		logic [31:0] in_timestamp;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  popped_seqnum;
		logic [31:0] popped_timestamp;
		logic        head_valid;
		logic [7:0]  head_seqnum;
		logic [31:0] head_timestamp;
		logic [5:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  seqnum;
		logic [31:0] timestamp;
	} entry_t;

	typedef struct packed {
		logic        en;
		logic        ins;
		logic [7:0]  seqnum;
		logic [31:0] timestamp;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: design/tpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_cell
// One slot of the sorted chain. Closes a gap from its tail-side neighbor,
// then keeps, takes the new entry or takes the head-side neighbor's entry.
// ----------------------------------------------------------------------------
module tpq_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tpq_pkg::cell_ctl_t ctl,
	input  wire logic              shift,
	input  wire tpq_pkg::entry_t   right_cur,
	input  wire tpq_pkg::entry_t   left_r,
	input  wire logic              left_lt,
	output tpq_pkg::entry_t        cur,
	output tpq_pkg::entry_t        r_out,
	output logic                   lt_out,
	output logic                   match,
	output tpq_pkg::entry_t        nxt
);
	import tpq_pkg::*;

	logic        valid_q;
	logic [7:0]  seqnum_q;
	logic [31:0] timestamp_q;
	entry_t      r;
	logic        lt;

	assign cur   = '{valid: valid_q, seqnum: seqnum_q, timestamp: timestamp_q};
	assign match = valid_q && (seqnum_q == ctl.seqnum);

	always_comb begin
		r  = shift ? right_cur : cur;
		lt = r.valid && (r.timestamp < ctl.timestamp);
		if (!ctl.ins || lt) begin
			nxt = r;
		end else if (left_lt) begin
			nxt = '{valid: 1'b1, seqnum: ctl.seqnum, timestamp: ctl.timestamp};
		end else begin
			nxt = left_r;
		end
	end

	assign r_out  = r;
	assign lt_out = lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			seqnum_q    <= nxt.seqnum;
			timestamp_q <= nxt.timestamp;
		end
	end

endmodule

`default_nettype wire

// File: design/timestamp_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_priority_queue_unit
// Bounded min-queue of sequence numbers keyed by timestamp, held as a sorted
// chain of cells with the head in cell 0. Push, pop and update by sequence
// number each finish in the cycle they are accepted.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; cells move at most one place.
// Reset: all cells empty, count zero, no result pending.
// ----------------------------------------------------------------------------
module timestamp_priority_queue_unit #(
	parameter int CAPACITY = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tpq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tpq_pkg::rsp_t      rsp
);
	import tpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]       count_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	entry_t              cur   [CAPACITY];
	entry_t              rr    [CAPACITY];
	entry_t              nxt   [CAPACITY];
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] match_v;
	logic [CAPACITY-1:0] above_v;
	logic [CAPACITY-1:0] valid_v;
	logic [CAPACITY-1:0] shift_v;

	logic                accept;
	logic                found;
	logic                push_ok;
	logic                pop_ok;
	logic                upd_ok;
	cell_ctl_t           ctl;
	logic [CW-1:0]       count_d;
	logic [CW+5:0]       count_ext;
	entry_t              head;
	rsp_t                rsp_d;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign found     = |match_v;

	assign push_ok = (req.func == FUNC_PUSH) && (count_q < CW'(CAPACITY));
	assign pop_ok  = (req.func == FUNC_POP) && (count_q != '0);
	assign upd_ok  = (req.func == FUNC_UPDATE) && found;

	assign ctl = '{en: accept && (push_ok || pop_ok || upd_ok),
	               ins: push_ok || upd_ok,
	               seqnum: req.in_seqnum,
	               timestamp: req.in_timestamp};

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			above_v[i] = |(match_v >> (i + 1));
			shift_v[i] = pop_ok || (upd_ok && !above_v[i]);
			valid_v[i] = cur[i].valid;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		entry_t right_e;
		entry_t left_e;
		logic   left_l;
		if (g == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = cur[g+1];
		end
		if (g == 0) begin : g_head
			assign left_e = '0;
			assign left_l = 1'b1;
		end else begin : g_body
			assign left_e = rr[g-1];
			assign left_l = lt_v[g-1];
		end
		tpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.shift     (shift_v[g]),
			.right_cur (right_e),
			.left_r    (left_e),
			.left_lt   (left_l),
			.cur       (cur[g]),
			.r_out     (rr[g]),
			.lt_out    (lt_v[g]),
			.match     (match_v[g]),
			.nxt       (nxt[g])
		);
	end

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CW'(1);
		end else if (pop_ok) begin
			count_d = count_q - CW'(1);
		end
		count_ext = {6'd0, count_d};
		head      = ctl.en ? nxt[0] : cur[0];

		rsp_d = '0;
		case (req.func)
			FUNC_PUSH: begin
				if (!push_ok) rsp_d.status = STATUS_FULL;
			end
			FUNC_POP: begin
				if (pop_ok) begin
					rsp_d.popped_seqnum    = cur[0].seqnum;
					rsp_d.popped_timestamp = cur[0].timestamp;
				end else begin
					rsp_d.status = STATUS_EMPTY;
				end
			end
			FUNC_UPDATE: begin
				if (!upd_ok) rsp_d.status = STATUS_NOT_FOUND;
			end
			default: rsp_d.status = STATUS_OK;
		endcase
		rsp_d.head_valid = head.valid;
		if (head.valid) begin
			rsp_d.head_seqnum    = head.seqnum;
			rsp_d.head_timestamp = head.timestamp;
		end
		rsp_d.entry_count = count_ext[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_v & (valid_v + CAPACITY'(1))) == '0)
		else $error("occupied cells not packed toward the head");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item gave no result");

endmodule

`default_nettype wire
